// ===== rtl/pidd_pkg.sv =====
// Shared types and constants for the dual-output PID controller.
// Holds field widths, request and register codes, sequencer states and the
// multiply-accumulate control bundle. No dependencies.
package pidd_pkg;

  // Field widths.
  localparam int DATA_W    = 32;
  localparam int GAIN_W    = 32;
  localparam int REQ_W     = 2;
  localparam int CFG_IDX_W = 3;

  // Default integrator width (Q16.16 with extra integer headroom).
  localparam int INTEG_WIDTH_DEF = 48;

  // Drive the second output with the negated drive when set.
  localparam bit INVERT_SECOND = 1'b0;

  // Gains are Q8.24, so a gain product carries 24 extra fraction bits.
  localparam int FRAC_SHIFT = 24;

  // Shared multiplier operand and product widths.
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;

  // Divider: output limit scaled by 2^24, divided by a 32-bit gain.
  localparam int DIV_NUM_W = DATA_W + FRAC_SHIFT;
  localparam int DIV_Q_W   = DIV_NUM_W + 1;

  // Signed range limits of a 32-bit field.
  localparam logic signed [DATA_W-1:0] DATA_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] DATA_MIN = 32'sh8000_0000;

  // Output range defaults: -1.0 and +1.0 in Q16.16.
  localparam logic signed [DATA_W-1:0] OUT_MIN_RST = -32'sd65536;
  localparam logic signed [DATA_W-1:0] OUT_MAX_RST = 32'sd65536;

  // Request codes of an input beat.
  typedef enum logic [REQ_W-1:0] {
    REQ_SAMPLE  = 2'd0,
    REQ_ENABLE  = 2'd1,
    REQ_DISABLE = 2'd2,
    REQ_RESET   = 2'd3
  } req_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN     = 3'd0,
    REG_INTEG_GAIN    = 3'd1,
    REG_DERIV_GAIN    = 3'd2,
    REG_IN_RANGE_MIN  = 3'd3,
    REG_IN_RANGE_MAX  = 3'd4,
    REG_OUT_RANGE_MIN = 3'd5,
    REG_OUT_RANGE_MAX = 3'd6,
    REG_WRAP_MODE     = 3'd7
  } cfg_reg_t;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CLAMP,
    ST_ERR,
    ST_WRAP,
    ST_CAND,
    ST_POT_LO,
    ST_POT_HI,
    ST_POT_DRAIN,
    ST_POT_CHK,
    ST_DIV,
    ST_SUM_CLR,
    ST_MUL_P,
    ST_MUL_IL,
    ST_MUL_IH,
    ST_MUL_D,
    ST_DRAIN,
    ST_SAT,
    ST_DONE
  } state_t;

  // Control bundle from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic clear;     // zero the accumulator
    logic issue;     // start a multiplication this cycle
    logic hi_shift;  // weight the product by 2^32 when it is added
  } mac_ctl_t;

endpackage

// ===== rtl/pidd_if.sv =====
// Valid/ready channel interfaces of the dual-output PID controller:
// configuration writes, input requests and results.
// Depends on pidd_pkg for field widths.
interface pidd_cfg_if import pidd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

interface pidd_in_if import pidd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [REQ_W-1:0]         req_type;
  logic signed [DATA_W-1:0] measurement;
  logic signed [DATA_W-1:0] target;

  modport source (output valid, req_type, measurement, target, input ready);
  modport sink   (input valid, req_type, measurement, target, output ready);
endinterface

interface pidd_out_if import pidd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] drive_primary;
  logic signed [DATA_W-1:0] drive_secondary;
  logic                     primary_written;
  logic                     secondary_written;
  logic signed [DATA_W-1:0] error_now;
  logic                     running;

  modport source (output valid, drive_primary, drive_secondary, primary_written,
                  secondary_written, error_now, running, input ready);
  modport sink   (input valid, drive_primary, drive_secondary, primary_written,
                  secondary_written, error_now, running, output ready);
endinterface

// ===== rtl/pidd_mac.sv =====
// Shared multiply-accumulate unit: one registered 33x33 signed multiplier
// whose registered product feeds a wide accumulator register.
// Depends on pidd_pkg for operand widths and the control bundle.
module pidd_mac import pidd_pkg::*; #(
  parameter int ACC_W = INTEG_WIDTH_DEF + 34
) (
  input  logic                    clk,
  input  logic                    rst,
  input  mac_ctl_t                ctl,
  input  logic signed [MUL_W-1:0] op_a,
  input  logic signed [MUL_W-1:0] op_b,
  output logic signed [ACC_W-1:0] acc
);

  logic signed [PROD_W-1:0] prod;
  logic                     prod_vld;
  logic                     prod_hi;
  logic signed [ACC_W-1:0]  term;

  // Product stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
      prod_hi  <= 1'b0;
    end else begin
      prod_vld <= ctl.issue;
      prod_hi  <= ctl.hi_shift;
    end
    if (ctl.issue) begin
      prod <= op_a * op_b;
    end
  end

  // Upper partial products land 32 bits higher.
  always_comb begin
    if (prod_hi) begin
      term = ACC_W'(prod) <<< 32;
    end else begin
      term = ACC_W'(prod);
    end
  end

  // Accumulate stage.
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= acc + term;
    end
  end

endmodule

// ===== rtl/pidd_div.sv =====
// Signed divider for the anti-windup clamp: restoring division of a scaled
// output limit by the integral gain, one quotient bit per cycle.
// Depends on pidd_pkg for operand widths.
module pidd_div import pidd_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic signed [DIV_NUM_W-1:0] num,
  input  logic signed [GAIN_W-1:0]  den,
  output logic                      done,
  output logic signed [DIV_Q_W-1:0] quot
);

  localparam int CntW = $clog2(DIV_NUM_W);

  logic                       prep;
  logic                       busy;
  logic [CntW-1:0]            cnt;
  logic signed [DIV_NUM_W-1:0] num_raw;
  logic signed [GAIN_W-1:0]   den_raw;
  logic [DIV_NUM_W-1:0]       qr;
  logic [GAIN_W-1:0]          dmag;
  logic [GAIN_W-1:0]          rem;
  logic                       neg;
  logic [GAIN_W:0]            shifted;
  logic [GAIN_W:0]            diff;
  logic                       fits;
  logic signed [DIV_Q_W-1:0]  qpos;

  // One restoring step: bring down the next dividend bit and try a subtract.
  always_comb begin
    shifted = {rem, qr[DIV_NUM_W-1]};
    fits    = shifted >= {1'b0, dmag};
    diff    = shifted - {1'b0, dmag};
    qpos    = $signed({1'b0, qr});
    quot    = neg ? -qpos : qpos;
  end

  // Control: latch, take magnitudes, then step once per bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      prep <= 1'b0;
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        prep <= 1'b1;
      end else if (prep) begin
        prep <= 1'b0;
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CntW'(DIV_NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: operand magnitudes, remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      num_raw <= num;
      den_raw <= den;
    end else if (prep) begin
      qr   <= num_raw[DIV_NUM_W-1] ? DIV_NUM_W'(-num_raw) : DIV_NUM_W'(num_raw);
      dmag <= den_raw[GAIN_W-1] ? GAIN_W'(-den_raw) : GAIN_W'(den_raw);
      neg  <= num_raw[DIV_NUM_W-1] ^ den_raw[GAIN_W-1];
      rem  <= '0;
    end else if (busy) begin
      rem <= fits ? diff[GAIN_W-1:0] : shifted[GAIN_W-1:0];
      qr  <= {qr[DIV_NUM_W-2:0], fits};
    end
  end

endmodule

// ===== rtl/pid_controller_dual_output.sv =====
// Dual-output PID controller. A control beat (enable, disable, reset, or a sample
// while disabled) goes straight to the result; an enabled sample runs the error,
// integrator and multiply steps, skips the windup test with a zero integral gain,
// and waits on the bit-serial divider when the integrator clamps. One beat is in
// work at a time; the next is accepted once the result is registered, and a
// stalled result holds the sequencer. Reset is synchronous, no sweep.
module pid_controller_dual_output import pidd_pkg::*; #(
  parameter int INTEG_WIDTH = INTEG_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  pidd_cfg_if.sink     cfg,
  pidd_in_if.sink      samp,
  pidd_out_if.source   result
);

  localparam int AccW = INTEG_WIDTH + 34;
  localparam int ExtW = 66;
  localparam int ErrW = 35;

  // Integrator saturation bounds, sign-extended to the compare width.
  localparam logic signed [ExtW-1:0] IntegMax =
    (ExtW'(1) <<< (INTEG_WIDTH - 1)) - ExtW'(1);
  localparam logic signed [ExtW-1:0] IntegMin = ~IntegMax;

  // Configuration registers.
  logic signed [GAIN_W-1:0] kp, ki, kd;
  logic signed [DATA_W-1:0] imin, imax, omin, omax;
  logic                     wrap;

  // Controller state.
  logic                          enabled;
  logic signed [DATA_W-1:0]      prior_error;
  logic signed [DATA_W-1:0]      latest_error;
  logic signed [INTEG_WIDTH-1:0] integral;

  // Working registers of one beat.
  state_t                        state, state_next;
  req_t                          req_q;
  logic                          smp_q;
  logic signed [DATA_W-1:0]      meas_q, tgt_q;
  logic signed [DATA_W:0]        diff_q, span_q;
  logic signed [DATA_W-1:0]      err_q;
  logic signed [INTEG_WIDTH-1:0] cand_q;
  logic signed [DATA_W-1:0]      r_q;

  // Result register.
  logic                     out_valid;
  logic signed [DATA_W-1:0] out_p, out_s, out_err;
  logic                     out_pw, out_sw, out_run;

  // Shared unit hookup.
  mac_ctl_t                    mac_ctl;
  logic signed [MUL_W-1:0]     mac_a, mac_b;
  logic signed [AccW-1:0]      acc;
  logic                        div_start, div_done;
  logic signed [DIV_NUM_W-1:0] div_num;
  logic signed [DIV_Q_W-1:0]   div_quot;

  // Combinational datapath.
  logic                     samp_acc, out_free, load_out;
  logic signed [63:0]       cand64, integ64;
  logic signed [ErrW-1:0]   d35, s35, mag35, wrapped;
  logic signed [DATA_W-1:0] err_sat;
  logic signed [ExtW-1:0]   cand_ext, quot_ext;
  logic signed [INTEG_WIDTH-1:0] cand_sat, quot_sat;
  logic signed [DIV_NUM_W-1:0]   omax_sc, omin_sc;
  logic                     below_hi, above_lo, pot_ok;
  logic signed [AccW-1:0]   acc_sh;
  logic signed [DATA_W-1:0] r_sat, r_neg;
  logic signed [DATA_W-1:0] res_p, res_s, res_err;
  logic                     res_pw, res_sw, res_run;

  assign samp_acc = samp.valid && samp.ready;
  assign out_free = !out_valid || result.ready;
  assign cfg.ready = 1'b1;

  pidd_mac #(.ACC_W(AccW)) u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mac_ctl),
    .op_a (mac_a),
    .op_b (mac_b),
    .acc  (acc)
  );

  pidd_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (ki),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      kp   <= '0;
      ki   <= '0;
      kd   <= '0;
      imin <= '0;
      imax <= '0;
      omin <= OUT_MIN_RST;
      omax <= OUT_MAX_RST;
      wrap <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_PROP_GAIN:     kp   <= cfg.data;
        REG_INTEG_GAIN:    ki   <= cfg.data;
        REG_DERIV_GAIN:    kd   <= cfg.data;
        REG_IN_RANGE_MIN:  imin <= cfg.data;
        REG_IN_RANGE_MAX:  imax <= cfg.data;
        REG_OUT_RANGE_MIN: omin <= cfg.data;
        REG_OUT_RANGE_MAX: omax <= cfg.data;
        REG_WRAP_MODE:     wrap <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // Error wrap on a circular range, then saturation to 32 bits.
  always_comb begin
    d35   = ErrW'(diff_q);
    s35   = ErrW'(span_q);
    mag35 = (d35 < 0) ? -d35 : d35;
    if (wrap && ((mag35 <<< 1) > s35)) begin
      wrapped = (d35 > 0) ? (d35 - s35) : (d35 + s35);
    end else begin
      wrapped = d35;
    end
    if (wrapped > ErrW'(DATA_MAX)) begin
      err_sat = DATA_MAX;
    end else if (wrapped < ErrW'(DATA_MIN)) begin
      err_sat = DATA_MIN;
    end else begin
      err_sat = wrapped[DATA_W-1:0];
    end
  end

  // Integrator candidate and clamp quotient, both saturated to the integrator width.
  always_comb begin
    cand_ext = ExtW'(integral) + ExtW'(err_q);
    if (cand_ext > IntegMax) begin
      cand_sat = IntegMax[INTEG_WIDTH-1:0];
    end else if (cand_ext < IntegMin) begin
      cand_sat = IntegMin[INTEG_WIDTH-1:0];
    end else begin
      cand_sat = cand_ext[INTEG_WIDTH-1:0];
    end
    quot_ext = ExtW'(div_quot);
    if (quot_ext > IntegMax) begin
      quot_sat = IntegMax[INTEG_WIDTH-1:0];
    end else if (quot_ext < IntegMin) begin
      quot_sat = IntegMin[INTEG_WIDTH-1:0];
    end else begin
      quot_sat = quot_ext[INTEG_WIDTH-1:0];
    end
  end

  // Windup test of Ki times the candidate against the scaled output limits.
  always_comb begin
    cand64   = 64'(cand_q);
    integ64  = 64'(integral);
    omax_sc  = {omax, {FRAC_SHIFT{1'b0}}};
    omin_sc  = {omin, {FRAC_SHIFT{1'b0}}};
    below_hi = acc < AccW'(omax_sc);
    above_lo = acc > AccW'(omin_sc);
    pot_ok   = below_hi && above_lo;
    div_num  = below_hi ? omin_sc : omax_sc;
  end

  // Drive: drop the gain fraction and saturate to the output range.
  always_comb begin
    acc_sh = acc >>> FRAC_SHIFT;
    if (acc_sh > AccW'(omax)) begin
      r_sat = omax;
    end else if (acc_sh < AccW'(omin)) begin
      r_sat = omin;
    end else begin
      r_sat = acc_sh[DATA_W-1:0];
    end
    r_neg = (r_q == DATA_MIN) ? DATA_MAX : -r_q;
  end

  // Result fields of the beat in hand.
  always_comb begin
    res_p   = '0;
    res_s   = '0;
    res_pw  = 1'b0;
    res_sw  = 1'b0;
    res_err = latest_error;
    res_run = enabled;
    if (smp_q) begin
      res_p   = r_q;
      res_s   = INVERT_SECOND ? r_neg : r_q;
      res_pw  = 1'b1;
      res_sw  = 1'b1;
      res_err = err_q;
      res_run = 1'b1;
    end else begin
      case (req_q)
        REQ_ENABLE:  res_run = 1'b1;
        REQ_DISABLE: begin
          res_pw  = 1'b1;
          res_run = 1'b0;
        end
        REQ_RESET: begin
          res_pw  = 1'b1;
          res_run = 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Sequencer: next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (samp_acc) begin
          if ((req_t'(samp.req_type) == REQ_SAMPLE) && enabled) begin
            state_next = ST_CLAMP;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_CLAMP:     state_next = ST_ERR;
      ST_ERR:       state_next = ST_WRAP;
      ST_WRAP:      state_next = (ki != '0) ? ST_CAND : ST_SUM_CLR;
      ST_CAND:      state_next = ST_POT_LO;
      ST_POT_LO:    state_next = ST_POT_HI;
      ST_POT_HI:    state_next = ST_POT_DRAIN;
      ST_POT_DRAIN: state_next = ST_POT_CHK;
      ST_POT_CHK:   state_next = pot_ok ? ST_SUM_CLR : ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_SUM_CLR;
        end
      end
      ST_SUM_CLR:   state_next = ST_MUL_P;
      ST_MUL_P:     state_next = ST_MUL_IL;
      ST_MUL_IL:    state_next = ST_MUL_IH;
      ST_MUL_IH:    state_next = ST_MUL_D;
      ST_MUL_D:     state_next = ST_DRAIN;
      ST_DRAIN:     state_next = ST_SAT;
      ST_SAT:       state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:      state_next = ST_IDLE;
    endcase
  end

  // Sequencer: outputs to the handshake, the shared multiplier and the divider.
  always_comb begin
    samp.ready = 1'b0;
    mac_ctl    = '0;
    mac_a      = '0;
    mac_b      = '0;
    div_start  = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: samp.ready = 1'b1;
      ST_CAND: mac_ctl.clear = 1'b1;
      ST_POT_LO: begin
        mac_ctl.issue = 1'b1;
        mac_a = MUL_W'(ki);
        mac_b = {1'b0, cand64[31:0]};
      end
      ST_POT_HI: begin
        mac_ctl.issue    = 1'b1;
        mac_ctl.hi_shift = 1'b1;
        mac_a = MUL_W'(ki);
        mac_b = {cand64[63], cand64[63:32]};
      end
      ST_POT_CHK: div_start = !pot_ok;
      ST_SUM_CLR: mac_ctl.clear = 1'b1;
      ST_MUL_P: begin
        mac_ctl.issue = 1'b1;
        mac_a = MUL_W'(kp);
        mac_b = MUL_W'(err_q);
      end
      ST_MUL_IL: begin
        mac_ctl.issue = 1'b1;
        mac_a = MUL_W'(ki);
        mac_b = {1'b0, integ64[31:0]};
      end
      ST_MUL_IH: begin
        mac_ctl.issue    = 1'b1;
        mac_ctl.hi_shift = 1'b1;
        mac_a = MUL_W'(ki);
        mac_b = {integ64[63], integ64[63:32]};
      end
      ST_MUL_D: begin
        mac_ctl.issue = 1'b1;
        mac_a = MUL_W'(kd);
        mac_b = MUL_W'(err_q) - MUL_W'(prior_error);
      end
      ST_DONE: load_out = out_free;
      default: ;
    endcase
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Beat datapath registers.
  always_ff @(posedge clk) begin
    if (samp_acc) begin
      req_q  <= req_t'(samp.req_type);
      smp_q  <= (req_t'(samp.req_type) == REQ_SAMPLE) && enabled;
      meas_q <= samp.measurement;
      tgt_q  <= samp.target;
    end
    case (state)
      ST_CLAMP: begin
        if (imax > imin) begin
          if (tgt_q > imax) begin
            tgt_q <= imax;
          end else if (tgt_q < imin) begin
            tgt_q <= imin;
          end
        end
      end
      ST_ERR: begin
        diff_q <= (DATA_W + 1)'(tgt_q) - (DATA_W + 1)'(meas_q);
        span_q <= (DATA_W + 1)'(imax) - (DATA_W + 1)'(imin);
      end
      ST_WRAP: err_q  <= err_sat;
      ST_CAND: cand_q <= cand_sat;
      ST_SAT:  r_q    <= r_sat;
      default: ;
    endcase
  end

  // Controller state: integrator updates mid-sample or on a reset request, the rest at result time.
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled      <= 1'b0;
      prior_error  <= '0;
      latest_error <= '0;
      integral     <= '0;
    end else begin
      if ((state == ST_POT_CHK) && pot_ok) begin
        integral <= cand_q;
      end else if ((state == ST_DIV) && div_done) begin
        integral <= quot_sat;
      end
      if (load_out) begin
        if (smp_q) begin
          prior_error  <= err_q;
          latest_error <= err_q;
        end else begin
          case (req_q)
            REQ_ENABLE:  enabled <= 1'b1;
            REQ_DISABLE: enabled <= 1'b0;
            REQ_RESET: begin
              enabled     <= 1'b0;
              prior_error <= '0;
              integral    <= '0;
            end
            default: ;
          endcase
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
    if (load_out) begin
      out_p   <= res_p;
      out_s   <= res_s;
      out_pw  <= res_pw;
      out_sw  <= res_sw;
      out_err <= res_err;
      out_run <= res_run;
    end
  end

  assign result.valid             = out_valid;
  assign result.drive_primary     = out_p;
  assign result.drive_secondary   = out_s;
  assign result.primary_written   = out_pw;
  assign result.secondary_written = out_sw;
  assign result.error_now         = out_err;
  assign result.running           = out_run;

endmodule

// ===== rtl/pidd_chk.sv =====
// Port-level checker for the dual-output PID controller, bound to the top.
// Watches the input handshake and the result channel only. Depends on pidd_pkg.
module pidd_chk import pidd_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     samp_valid,
  input logic                     samp_ready,
  input logic                     res_valid,
  input logic                     res_ready,
  input logic signed [DATA_W-1:0] res_drive_primary,
  input logic signed [DATA_W-1:0] res_drive_secondary,
  input logic                     res_primary_written,
  input logic                     res_secondary_written,
  input logic                     res_running
);

  // No result is shown right after reset.
  a_reset_idle: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  // A stalled result beat holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_drive_primary)
      && $stable(res_drive_secondary))
    else $error("stalled result beat changed");

  // The second output is only written by a sample of a running controller.
  a_second: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_secondary_written |-> res_primary_written && res_running)
    else $error("second output written without a running sample");

  // An output that is not written reads as zero.
  a_unwritten_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_primary_written || res_drive_primary == '0)
      && (res_secondary_written || res_drive_secondary == '0))
    else $error("unwritten drive field is not zero");

  // One beat at a time: the block is busy the cycle after accepting one.
  a_one_beat: assert property (@(posedge clk) disable iff (rst)
    samp_valid && samp_ready |=> !samp_ready)
    else $error("input accepted on back-to-back cycles");

endmodule

bind pid_controller_dual_output pidd_chk u_pidd_chk (
  .clk                   (clk),
  .rst                   (rst),
  .samp_valid            (samp.valid),
  .samp_ready            (samp.ready),
  .res_valid             (result.valid),
  .res_ready             (result.ready),
  .res_drive_primary     (result.drive_primary),
  .res_drive_secondary   (result.drive_secondary),
  .res_primary_written   (result.primary_written),
  .res_secondary_written (result.secondary_written),
  .res_running           (result.running)
);
